### rtl/asrm_pkg.sv
`default_nettype none
package asrm_pkg;

    localparam int SLOTS      = 8;
    localparam int RING_DEPTH = 4096;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RING_W     = $clog2(RING_DEPTH);
    localparam int ADDR_W     = SLOT_W + RING_W;
    localparam int FILL_W     = 13;
    localparam int CNT_W      = 32;
    localparam int SMP_W      = 24;

    typedef enum logic [2:0] {
        K_CREATE  = 3'd0,
        K_RELEASE = 3'd1,
        K_ACCUM   = 3'd2,
        K_DRAIN   = 3'd3,
        K_QUERY   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_CLEAR,
        S_READ,
        S_WB
    } t_state;

    typedef struct packed {
        logic capture;
        logic create_init;
        logic clr_wr;
        logic ram_rd;
        logic writeback;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       free_found;
        logic       active;
        logic       clr_last;
        logic       out_busy;
    } t_sts;

endpackage
`default_nettype wire

### rtl/asrm_ram.sv
`default_nettype none
module asrm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/asrm_ctrl.sv
`default_nettype none
module asrm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire asrm_pkg::t_sts i_sts,
    output asrm_pkg::t_cmd      o_cmd
);
    import asrm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.kind)
                    K_CREATE: begin
                        if (i_sts.free_found) begin
                            o_cmd.create_init = 1'b1;
                            n_state           = S_CLEAR;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    K_ACCUM, K_DRAIN: begin
                        if (i_sts.active) begin
                            n_state = S_READ;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                o_cmd.writeback = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE && !i_sts.out_busy))
        else $error("ready outside idle");
    a_read_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_WB))
        else $error("read not followed by writeback");
    a_clear_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_sts.clr_last) |=> (r_state == S_CLEAR))
        else $error("clear sweep cut short");
endmodule
`default_nettype wire

### rtl/asrm_dp.sv
`default_nettype none
module asrm_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire asrm_pkg::t_cmd i_cmd,
    output asrm_pkg::t_sts      o_sts,
    input  wire logic [2:0]     i_kind,
    input  wire logic [2:0]     i_send_id,
    input  wire logic [15:0]    i_offset,
    input  wire logic           i_last,
    input  wire logic [15:0]    i_sample,
    input  wire logic [15:0]    i_gain,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [191:0]        o_out_data
);
    import asrm_pkg::*;

    logic [2:0]         r_kind;
    logic [2:0]         r_id;
    logic [15:0]        r_off;
    logic               r_last;
    logic signed [31:0] r_prod;
    logic signed [19:0] r_add;
    logic [SLOT_W-1:0]  r_free;
    logic [RING_W-1:0]  r_clr;
    logic               r_out_valid;
    logic [191:0]       r_out;

    logic [SLOTS-1:0]  r_in_use;
    logic [RING_W-1:0] r_head [SLOTS];
    logic [FILL_W-1:0] r_fill [SLOTS];
    logic [FILL_W-1:0] r_peak [SLOTS];
    logic [CNT_W-1:0]  r_ab [SLOTS];
    logic [CNT_W-1:0]  r_as [SLOTS];
    logic [CNT_W-1:0]  r_db [SLOTS];
    logic [CNT_W-1:0]  r_ds [SLOTS];

    logic [SLOT_W-1:0] idx;
    logic              id_ok;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [16:0]       n_len;
    logic [FILL_W-1:0] m_len;
    logic [FILL_W-1:0] acc_fill;
    logic [FILL_W-1:0] drn_fill;
    logic [RING_W-1:0] ring_pos;
    logic [ADDR_W-1:0] rw_addr;
    logic [SMP_W-1:0]  rdata;
    logic signed [24:0] acc_sum;
    logic [SMP_W-1:0]  acc_sat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SMP_W-1:0]  ram_wdata;
    logic [3:0]        used_cnt;
    logic [191:0]      res;
    logic [32:0]       ab_sum, as_sum, db_sum, ds_sum;

    assign idx   = SLOT_W'(r_id);
    assign id_ok = (32'(r_id) < SLOTS);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        used_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            used_cnt = used_cnt + 4'(r_in_use[i]);
        end
    end

    assign n_len    = {1'b0, r_off} + 17'd1;
    assign m_len    = (n_len < 17'(RING_DEPTH)) ? FILL_W'(n_len) : FILL_W'(RING_DEPTH);
    assign acc_fill = (m_len > r_fill[idx]) ? m_len : r_fill[idx];
    assign drn_fill = (17'(r_fill[idx]) > n_len) ? FILL_W'(17'(r_fill[idx]) - n_len) : '0;
    assign ring_pos = r_head[idx] + RING_W'(r_off);
    assign rw_addr  = {idx, ring_pos};

    assign acc_sum = 25'(signed'(rdata)) + 25'(r_add);
    always_comb begin
        if (acc_sum > 25'sd8388607) begin
            acc_sat = 24'h7FFFFF;
        end else if (acc_sum < -25'sd8388608) begin
            acc_sat = 24'h800000;
        end else begin
            acc_sat = acc_sum[23:0];
        end
    end

    assign ab_sum = {1'b0, r_ab[idx]} + 33'd1;
    assign as_sum = {1'b0, r_as[idx]} + 33'(m_len);
    assign db_sum = {1'b0, r_db[idx]} + 33'd1;
    assign ds_sum = {1'b0, r_ds[idx]} + 33'(n_len);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rw_addr;
        ram_wdata = '0;
        if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = {r_free, r_clr};
        end else if (i_cmd.writeback) begin
            if (r_kind == K_ACCUM) begin
                ram_we    = (32'(r_off) < RING_DEPTH);
                ram_wdata = acc_sat;
            end else begin
                ram_we = 1'b1;
            end
        end
    end

    asrm_ram #(.WIDTH(SMP_W), .DEPTH(SLOTS * RING_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.ram_rd),
        .i_raddr(rw_addr),
        .o_rdata(rdata)
    );

    always_comb begin
        res       = '0;
        res[24]   = 1'b1;
        if (i_cmd.writeback) begin
            if (r_kind == K_DRAIN && 17'(r_off) < 17'(r_fill[idx])) begin
                res[23:0] = rdata;
            end
        end else begin
            case (r_kind)
                K_CREATE: begin
                    res[24]    = free_found || (r_clr != '0) || i_cmd.clr_wr;
                    res[27:25] = i_cmd.clr_wr ? 3'(r_free) : 3'd0;
                end
                K_QUERY: begin
                    res[32:29] = used_cnt;
                    if (id_ok) begin
                        res[28]      = r_in_use[idx];
                        res[45:33]   = r_fill[idx];
                        res[58:46]   = r_peak[idx];
                        res[90:59]   = r_ab[idx];
                        res[122:91]  = r_as[idx];
                        res[154:123] = r_db[idx];
                        res[186:155] = r_ds[idx];
                    end
                end
                default: res = res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_id   <= i_send_id;
            r_off  <= i_offset;
            r_last <= i_last;
            r_prod <= signed'(i_sample) * signed'(i_gain);
        end
        if (i_cmd.ram_rd) begin
            r_add <= 20'((33'(r_prod) + 33'sd2048) >>> 12);
        end
        if (i_cmd.create_init) begin
            r_free <= free_idx;
        end
        if (i_cmd.finish || i_cmd.writeback) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr       <= '0;
            r_in_use    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
                r_peak[i] <= '0;
                r_ab[i]   <= '0;
                r_as[i]   <= '0;
                r_db[i]   <= '0;
                r_ds[i]   <= '0;
            end
        end else begin
            if (i_cmd.finish || i_cmd.writeback) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.create_init) begin
                r_in_use[free_idx] <= 1'b1;
                r_head[free_idx]   <= '0;
                r_fill[free_idx]   <= '0;
                r_peak[free_idx]   <= '0;
                r_ab[free_idx]     <= '0;
                r_as[free_idx]     <= '0;
                r_db[free_idx]     <= '0;
                r_ds[free_idx]     <= '0;
            end
            if (i_cmd.finish && r_kind == K_RELEASE && id_ok) begin
                r_in_use[idx] <= 1'b0;
            end
            if (i_cmd.writeback && r_last) begin
                if (r_kind == K_ACCUM) begin
                    r_fill[idx] <= acc_fill;
                    if (acc_fill > r_peak[idx]) begin
                        r_peak[idx] <= acc_fill;
                    end
                    r_ab[idx] <= ab_sum[32] ? '1 : ab_sum[31:0];
                    r_as[idx] <= as_sum[32] ? '1 : as_sum[31:0];
                end else begin
                    r_head[idx] <= r_head[idx] + RING_W'(n_len);
                    r_fill[idx] <= drn_fill;
                    r_db[idx]   <= db_sum[32] ? '1 : db_sum[31:0];
                    r_ds[idx]   <= ds_sum[32] ? '1 : ds_sum[31:0];
                end
            end
        end
    end

    assign o_sts.kind       = r_kind;
    assign o_sts.free_found = free_found;
    assign o_sts.active     = id_ok && r_in_use[idx];
    assign o_sts.clr_last   = &r_clr;
    assign o_sts.out_busy   = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result lost");
    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !r_out_valid)
        else $error("item taken while result pending");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.writeback |=> (r_fill[idx] <= FILL_W'(RING_DEPTH)))
        else $error("fill beyond ring");
endmodule
`default_nettype wire

### rtl/audio_send_ring_mixer.sv
// path: release, query, failed create and inactive slots finish in the decode state after
// the input beat; accumulate and drain pass decode, ring read and write back
// create with a free slot sweeps that slot's ring, clearing every entry before its result
// flow: one item at a time, next beat taken the cycle after the result beat
// reset: synchronous active low, frees all slots and zeroes statistics, ring undefined
`default_nettype none
module audio_send_ring_mixer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [55:0]  s_axis_tdata,  // send_id, offset, sample, gain
    input  wire logic [2:0]   s_axis_tuser,  // kind
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_sample, ok, slot_id, slot_used, used_count, fill_level, peak_fill,
    // accum_blocks, accum_samples, drain_blocks, drain_samples
    output logic [191:0]      m_axis_tdata
);
    import asrm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    asrm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    asrm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_kind     (s_axis_tuser),
        .i_send_id  (s_axis_tdata[2:0]),
        .i_offset   (s_axis_tdata[18:3]),
        .i_last     (s_axis_tlast),
        .i_sample   (s_axis_tdata[34:19]),
        .i_gain     (s_axis_tdata[50:35]),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (m_axis_tdata)
    );
endmodule
`default_nettype wire

### bench/asrm_checker.sv
`timescale 1ns / 1ps
module asrm_checker
    import asrm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [55:0]  i_s_tdata,  // send_id, offset, sample, gain
    input  wire logic [2:0]   i_s_tuser,  // kind
    input  wire logic         i_s_tlast,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // out_sample, ok, slot_id, slot_used, used_count, fill_level, peak_fill,
    // accum_blocks, accum_samples, drain_blocks, drain_samples
    input  wire logic [191:0] i_m_tdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] drain_samples;
        logic [31:0] drain_blocks;
        logic [31:0] accum_samples;
        logic [31:0] accum_blocks;
        logic [12:0] peak_fill;
        logic [12:0] fill_level;
        logic [3:0]  used_count;
        logic        slot_used;
        logic [2:0]  slot_id;
        logic        ok;
        logic [23:0] out_sample;
    } t_res;

    int          mix_ring [SLOTS*RING_DEPTH];
    bit          busy     [SLOTS];
    logic [11:0] head     [SLOTS];
    int unsigned lvl      [SLOTS];
    int unsigned lvl_peak [SLOTS];
    logic [31:0] acc_blk  [SLOTS];
    logic [31:0] acc_smp  [SLOTS];
    logic [31:0] drn_blk  [SLOTS];
    logic [31:0] drn_smp  [SLOTS];
    t_res        mix_results [$];

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_res mix_step(t_kind kind, logic [2:0] id, logic [15:0] off,
                                      logic lst, logic signed [15:0] smp,
                                      logic signed [15:0] gain);
        t_res        r;
        int unsigned n;
        int unsigned m;
        int          k;
        longint      v;
        r = '0;
        r.ok = 1'b1;
        n = off + 1;
        k = id * RING_DEPTH + ((head[id] + off) % RING_DEPTH);
        case (kind)
            K_CREATE: begin
                r.ok = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!busy[i] && !r.ok) begin
                        for (int j = 0; j < RING_DEPTH; j++) mix_ring[i*RING_DEPTH+j] = 0;
                        head[i] = 0; lvl[i] = 0; lvl_peak[i] = 0;
                        acc_blk[i] = 0; acc_smp[i] = 0; drn_blk[i] = 0; drn_smp[i] = 0;
                        busy[i] = 1;
                        r.ok = 1'b1;
                        r.slot_id = i;
                    end
                end
            end
            K_RELEASE: busy[id] = 0;
            K_ACCUM: begin
                if (busy[id]) begin
                    if (off < RING_DEPTH) begin
                        v = (longint'(smp) * longint'(gain) + 2048) >>> 12;
                        v = v + mix_ring[k];
                        if (v > 8388607) v = 8388607;
                        if (v < -8388608) v = -8388608;
                        mix_ring[k] = int'(v);
                    end
                    if (lst) begin
                        m = n < RING_DEPTH ? n : RING_DEPTH;
                        if (m > lvl[id]) lvl[id] = m;
                        if (lvl[id] > lvl_peak[id]) lvl_peak[id] = lvl[id];
                        acc_blk[id] = sat_sum(acc_blk[id], 1);
                        acc_smp[id] = sat_sum(acc_smp[id], m);
                    end
                end
            end
            K_DRAIN: begin
                if (busy[id]) begin
                    if (off < lvl[id]) r.out_sample = mix_ring[k][23:0];
                    mix_ring[k] = 0;
                    if (lst) begin
                        head[id] = (head[id] + n) % RING_DEPTH;
                        lvl[id] = lvl[id] > n ? lvl[id] - n : 0;
                        drn_blk[id] = sat_sum(drn_blk[id], 1);
                        drn_smp[id] = sat_sum(drn_smp[id], n);
                    end
                end
            end
            K_QUERY: begin
                for (int i = 0; i < SLOTS; i++) r.used_count += busy[i];
                r.slot_used = busy[id];
                r.fill_level = lvl[id];
                r.peak_fill = lvl_peak[id];
                r.accum_blocks = acc_blk[id];
                r.accum_samples = acc_smp[id];
                r.drain_blocks = drn_blk[id];
                r.drain_samples = drn_smp[id];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     o_checked, field, got, want);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    assign o_pending = mix_results.size();

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            mix_results.delete();
            for (int i = 0; i < SLOTS; i++) begin
                busy[i] = 0; head[i] = 0; lvl[i] = 0; lvl_peak[i] = 0;
                acc_blk[i] = 0; acc_smp[i] = 0; drn_blk[i] = 0; drn_smp[i] = 0;
            end
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (mix_results.size() == 0) begin
                    $display("unexpected result beat: %h", i_m_tdata);
                    o_errors++;
                end else begin
                    want = mix_results.pop_front();
                    report("out_sample", got.out_sample, want.out_sample);
                    report("ok", got.ok, want.ok);
                    report("slot_id", got.slot_id, want.slot_id);
                    report("slot_used", got.slot_used, want.slot_used);
                    report("used_count", got.used_count, want.used_count);
                    report("fill_level", got.fill_level, want.fill_level);
                    report("peak_fill", got.peak_fill, want.peak_fill);
                    report("accum_blocks", got.accum_blocks, want.accum_blocks);
                    report("accum_samples", got.accum_samples, want.accum_samples);
                    report("drain_blocks", got.drain_blocks, want.drain_blocks);
                    report("drain_samples", got.drain_samples, want.drain_samples);
                end
                o_checked++;
            end
            if (i_s_tvalid && i_s_tready)
                mix_results.push_back(mix_step(t_kind'(i_s_tuser), i_s_tdata[2:0],
                                               i_s_tdata[18:3], i_s_tlast,
                                               i_s_tdata[34:19], i_s_tdata[50:35]));
        end
    end

endmodule

### bench/tb_audio_send_ring_mixer.sv
`timescale 1ns / 1ps
module tb_audio_send_ring_mixer;
    import asrm_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;  // send_id, offset, sample, gain
    logic [2:0]   s_axis_tuser;  // kind
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // out_sample, ok, slot_id, slot_used, used_count, fill_level, peak_fill,
    // accum_blocks, accum_samples, drain_blocks, drain_samples
    logic [191:0] m_axis_tdata;

    int errors;
    int pending;
    int checked;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_cnt;
    int quiet_cycles;
    int items_sent;
    bit in_beat;

    audio_send_ring_mixer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    asrm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_beat <= s_axis_tvalid && s_axis_tready;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > 30000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic send(t_kind kind, logic [2:0] id, logic [15:0] off, logic lst,
                        logic [15:0] smp, logic [15:0] gain);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tlast <= lst;
        s_axis_tdata <= {5'd0, gain, smp, off, id};
        do @(negedge i_clk); while (!in_beat);
        items_sent++;
    endtask

    task automatic drain_out;
        s_axis_tvalid <= 1'b0;
        while (pending > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_level;
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic mix_block(logic [2:0] id, int len, int producers);
        for (int p = 0; p < producers; p++)
            for (int i = 0; i < len; i++)
                send(K_ACCUM, id, i, i == len - 1, pick_level(), pick_level());
        if ($urandom_range(3) == 0) send(K_QUERY, id, $urandom, $urandom, $urandom, $urandom);
        len = len + $urandom_range(2);
        for (int i = 0; i < len; i++)
            send(K_DRAIN, id, i, i == len - 1, $urandom, $urandom);
    endtask

    initial begin
        int len;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_cnt = 0;
        quiet_cycles = 0;
        items_sent = 0;
        in_beat = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SLOTS; i++) send(K_CREATE, 0, 0, 0, 0, 0);
        send(K_CREATE, 7, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
        send(K_QUERY, 3, 0, 0, 0, 0);
        send(K_ACCUM, 1, 0, 0, 16'h8000, 16'h8000);
        send(K_ACCUM, 1, 0, 1, 16'h7FFF, 16'h8000);
        send(K_ACCUM, 1, 16'hFFFF, 1, 16'h7FFF, 16'h7FFF);
        send(K_QUERY, 1, 0, 0, 0, 0);
        send(K_DRAIN, 1, 0, 0, 0, 0);
        send(K_DRAIN, 1, 16'hFFFF, 1, 0, 0);
        send(K_RELEASE, 7, 0, 0, 0, 0);
        send(K_ACCUM, 7, 0, 1, 16'h7FFF, 16'h7FFF);
        send(K_DRAIN, 7, 0, 1, 0, 0);
        send(K_QUERY, 7, 0, 0, 0, 0);
        send(K_CREATE, 0, 0, 0, 0, 0);
        send(K_QUERY, 7, 0, 0, 0, 0);
        // saturate one entry upward, then drain it
        for (int i = 0; i < 34; i++) send(K_ACCUM, 2, 0, 1, 16'h8000, 16'h8000);
        send(K_DRAIN, 2, 0, 1, 0, 0);
        drain_out();

        hold_req = 300;
        for (int i = 0; i < 12; i++) send(K_QUERY, $urandom, 0, 0, 0, 0);
        drain_out();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = ph == 1 ? 60 : ph == 3 ? 22 : 0;
            stall_pct = ph == 2 ? 60 : ph == 3 ? 22 : 0;
            while (items_sent < 100 + 370 * (ph + 1)) begin
                if ($urandom_range(9) < 7) begin
                    len = $urandom_range(19) == 0 ? $urandom_range(64, 1) : $urandom_range(12, 1);
                    mix_block($urandom, len, $urandom_range(2, 1));
                end else if ($urandom_range(29) == 0) begin
                    send(K_RELEASE, $urandom, $urandom, $urandom, $urandom, $urandom);
                    send(K_CREATE, $urandom, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    send(t_kind'($urandom_range(4, 1)), $urandom, $urandom, $urandom,
                         pick_level(), pick_level());
                end
            end
            drain_out();
        end

        $display("sent %0d items over four idle/stall mixes, %0d results checked",
                 items_sent, checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
